/* hw/rtl/tcw_pkg.sv */
package tcw_pkg;

  // default screen geometry
  localparam int SCREEN_COLS_DEF = 80;
  localparam int SCREEN_ROWS_DEF = 25;

  // character and attribute constants
  localparam logic [7:0] NEWLINE_CODE     = 8'd10;
  localparam logic [7:0] SPACE_CODE       = 8'd32;
  localparam logic [7:0] TEXT_COLOR_RESET = 8'd7;

  // command codes
  typedef enum logic [1:0] {
    CMD_PUT_CHAR  = 2'd0,
    CMD_PUT_AT    = 2'd1,
    CMD_CLEAR     = 2'd2,
    CMD_READ_CELL = 2'd3
  } cmd_code_t;

  // request payload
  typedef struct packed {
    cmd_code_t  cmd;
    logic [7:0] char_code;
    logic [6:0] cell_col;
    logic [4:0] cell_row;
  } cmd_t;

  // result payload
  typedef struct packed {
    logic [15:0] cell_word;
    logic [4:0]  cursor_row_out;
    logic [6:0]  cursor_col_out;
    logic        scrolled;
    logic        bad_position;
  } res_t;

endpackage

/* hw/rtl/tcw_stream_if.sv */
interface tcw_stream_if #(
  parameter type payload_t = logic
);

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (
    output valid,
    output payload,
    input  ready
  );

  modport sink (
    input  valid,
    input  payload,
    output ready
  );

endinterface

/* hw/rtl/tcw_ram.sv */
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/text_console_writer_core.sv */
// Text console engine: a screen of character cells (char in the low byte,
// attribute in the high byte) held in one block RAM, plus a cursor.
// cmd_stream takes requests (put_char, put_at, clear, read_cell) with a
// valid/ready handshake; res_stream returns one result per request in order.
// color_we/color_wdata load the attribute byte used for written cells.
// put_char without scroll, put_at and out-of-range requests finish in the
// cycle they are taken: one request per cycle while the result slots have
// room; the result passes through the finished result slot and the output
// register. read_cell also passes through S_READ for the registered RAM read.
// A scroll walks the RAM moving one cell per cycle through the read port;
// clear writes one cell per cycle. No request is taken during either walk.
// After reset the RAM is zeroed one cell per cycle while cmd_stream.ready
// stays low; the attribute resets to 7.
// A result and one more finished result are buffered, so a stalled receiver
// holds off new requests only once both slots are full.
module text_console_writer_core #(
  parameter int SCREEN_COLS = tcw_pkg::SCREEN_COLS_DEF,
  parameter int SCREEN_ROWS = tcw_pkg::SCREEN_ROWS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       color_we,
  input  logic [7:0] color_wdata,
  tcw_stream_if.sink   cmd_stream,
  tcw_stream_if.source res_stream
);

  localparam int CELLS      = SCREEN_ROWS * SCREEN_COLS;
  localparam int MOVE_CELLS = (SCREEN_ROWS - 1) * SCREEN_COLS;
  localparam int ADDR_W     = $clog2(CELLS);
  localparam int CNT_W      = $clog2(CELLS + 1);

  localparam logic [ADDR_W-1:0] LAST_ROW_ADDR = ADDR_W'(MOVE_CELLS);
  localparam logic [CNT_W-1:0]  CNT_LAST      = CNT_W'(CELLS - 1);
  localparam logic [CNT_W-1:0]  CNT_END       = CNT_W'(CELLS);
  localparam logic [CNT_W-1:0]  CNT_MOVE      = CNT_W'(MOVE_CELLS);
  localparam logic [CNT_W-1:0]  CNT_COLS      = CNT_W'(SCREEN_COLS);

  typedef enum logic [4:0] {
    S_INIT   = 5'b00001,
    S_IDLE   = 5'b00010,
    S_READ   = 5'b00100,
    S_SCROLL = 5'b01000,
    S_CLEAR  = 5'b10000
  } state_t;

  state_t              state, state_next;
  logic [CNT_W-1:0]    sweep_cnt;
  logic [7:0]          text_color;
  logic [4:0]          cursor_row, cursor_row_next;
  logic [6:0]          cursor_col, cursor_col_next;
  logic [ADDR_W-1:0]   cursor_addr, cursor_addr_next;
  tcw_pkg::res_t       res, res_fill, out_data;
  logic                res_valid, res_set, out_valid;

  tcw_pkg::cmd_t       req;
  logic                out_free, res_load, in_ready, accept;
  logic                in_range, last_col, last_row, is_newline, line_end;
  logic [ADDR_W-1:0]   pos_addr;
  logic [CNT_W-1:0]    scroll_src, sweep_prev;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_waddr, ram_raddr;
  logic [15:0]         ram_wdata, ram_rdata;

  tcw_ram #(
    .WIDTH (16),
    .DEPTH (CELLS)
  ) u_cells (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // handshake and request decode
  assign req        = cmd_stream.payload;
  assign out_free   = !out_valid || res_stream.ready;
  assign res_load   = res_valid && out_free;
  assign in_ready   = (state == S_IDLE) && (!res_valid || out_free);
  assign accept     = cmd_stream.valid && in_ready;
  assign in_range   = ({1'b0, req.cell_col} < 8'(SCREEN_COLS)) &&
                      ({1'b0, req.cell_row} < 6'(SCREEN_ROWS));
  assign pos_addr   = ADDR_W'(req.cell_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(req.cell_col);
  assign last_col   = cursor_col == 7'(SCREEN_COLS - 1);
  assign last_row   = cursor_row == 5'(SCREEN_ROWS - 1);
  assign is_newline = req.char_code == tcw_pkg::NEWLINE_CODE;
  assign line_end   = (req.cmd == tcw_pkg::CMD_PUT_CHAR) && (is_newline || last_col);
  assign scroll_src = sweep_cnt + CNT_COLS;
  assign sweep_prev = sweep_cnt - CNT_W'(1);

  assign cmd_stream.ready   = in_ready;
  assign res_stream.valid   = out_valid;
  assign res_stream.payload = out_data;

  // cursor update for put_char
  always_comb begin
    cursor_row_next  = cursor_row;
    cursor_col_next  = cursor_col;
    cursor_addr_next = cursor_addr;
    if (accept && req.cmd == tcw_pkg::CMD_PUT_CHAR) begin
      if (line_end) begin
        cursor_col_next = '0;
        if (last_row) begin
          cursor_addr_next = LAST_ROW_ADDR;
        end else begin
          cursor_row_next  = cursor_row + 5'd1;
          cursor_addr_next = cursor_addr - ADDR_W'(cursor_col) + ADDR_W'(SCREEN_COLS);
        end
      end else begin
        cursor_col_next  = cursor_col + 7'd1;
        cursor_addr_next = cursor_addr + ADDR_W'(1);
      end
    end
  end

  // ram port control and next state
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = cursor_addr;
    ram_wdata  = {text_color, req.char_code};
    ram_raddr  = pos_addr;
    unique case (state)
      S_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt[ADDR_W-1:0];
        ram_wdata = '0;
        if (sweep_cnt == CNT_LAST) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (req.cmd)
            tcw_pkg::CMD_PUT_CHAR: begin
              ram_we = !is_newline;
              if (line_end && last_row) begin
                state_next = S_SCROLL;
              end
            end
            tcw_pkg::CMD_PUT_AT: begin
              ram_we    = in_range;
              ram_waddr = pos_addr;
            end
            tcw_pkg::CMD_CLEAR: begin
              state_next = S_CLEAR;
            end
            tcw_pkg::CMD_READ_CELL: begin
              if (in_range) begin
                state_next = S_READ;
              end
            end
            default: begin
              state_next = S_IDLE;
            end
          endcase
        end
      end
      S_READ: begin
        state_next = S_IDLE;
      end
      S_SCROLL: begin
        // read one row ahead, write the cell fetched last cycle one behind
        ram_raddr = (sweep_cnt < CNT_MOVE) ? scroll_src[ADDR_W-1:0] : '0;
        ram_we    = sweep_cnt != '0;
        ram_waddr = sweep_prev[ADDR_W-1:0];
        ram_wdata = (sweep_cnt <= CNT_MOVE) ? ram_rdata : '0;
        if (sweep_cnt == CNT_END) begin
          state_next = S_IDLE;
        end
      end
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = sweep_cnt[ADDR_W-1:0];
        ram_wdata = {text_color, tcw_pkg::SPACE_CODE};
        if (sweep_cnt == CNT_LAST) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result assembly
  always_comb begin
    res_set                 = 1'b0;
    res_fill                = '0;
    res_fill.cursor_row_out = cursor_row_next;
    res_fill.cursor_col_out = cursor_col_next;
    if (state == S_IDLE && accept && state_next == S_IDLE) begin
      res_set               = 1'b1;
      res_fill.bad_position = (req.cmd == tcw_pkg::CMD_PUT_AT ||
                               req.cmd == tcw_pkg::CMD_READ_CELL) && !in_range;
    end else if (state == S_READ) begin
      res_set            = 1'b1;
      res_fill.cell_word = ram_rdata;
    end else if (state == S_SCROLL && state_next == S_IDLE) begin
      res_set           = 1'b1;
      res_fill.scrolled = 1'b1;
    end else if (state == S_CLEAR && state_next == S_IDLE) begin
      res_set = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_INIT;
      sweep_cnt   <= '0;
      text_color  <= tcw_pkg::TEXT_COLOR_RESET;
      cursor_row  <= '0;
      cursor_col  <= '0;
      cursor_addr <= '0;
      res_valid   <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      cursor_row  <= cursor_row_next;
      cursor_col  <= cursor_col_next;
      cursor_addr <= cursor_addr_next;
      if (color_we) begin
        text_color <= color_wdata;
      end
      // sweep counter restarts on every state change
      if (state_next != state) begin
        sweep_cnt <= '0;
      end else if (state == S_INIT || state == S_SCROLL || state == S_CLEAR) begin
        sweep_cnt <= sweep_cnt + CNT_W'(1);
      end
      // finished result slot
      if (res_set) begin
        res_valid <= 1'b1;
      end else if (res_load) begin
        res_valid <= 1'b0;
      end
      // output register
      if (res_load) begin
        out_valid <= 1'b1;
      end else if (res_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (res_set) begin
      res <= res_fill;
    end
    if (res_load) begin
      out_data <= res;
    end
  end

  // cursor stays on screen
  assert property (@(posedge clk) disable iff (rst)
    (cursor_row < 5'(SCREEN_ROWS)) && ({1'b0, cursor_col} < 8'(SCREEN_COLS)))
    else $error("cursor off screen");

  // linear cursor address tracks row and column
  assert property (@(posedge clk) disable iff (rst)
    cursor_addr == ADDR_W'(cursor_row) * ADDR_W'(SCREEN_COLS) + ADDR_W'(cursor_col))
    else $error("cursor address out of step");

  // a finished result is never overwritten before it moves out
  assert property (@(posedge clk) disable iff (rst)
    res_set |-> (!res_valid || res_load))
    else $error("result slot overrun");

  // a scroll leaves the cursor at the start of the bottom row
  assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.scrolled) |->
      (res.cursor_row_out == 5'(SCREEN_ROWS - 1)) && (res.cursor_col_out == '0))
    else $error("scroll result with cursor off bottom row");

endmodule

/* tb/console_result_check.sv */
`timescale 1ns / 1ps

module console_result_check
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        color_we,
  input  logic [7:0]  color_wdata,
  tcw_stream_if       cmd_mon,
  tcw_stream_if       res_mon,
  output int unsigned mismatch_count,
  output int unsigned results_owed
);

  localparam int COLS        = SCREEN_COLS_DEF;
  localparam int ROWS        = SCREEN_ROWS_DEF;
  localparam int CELLS       = COLS * ROWS;

  // shadow of the console: cell store, cursor and attribute byte
  logic [15:0] screen_img [CELLS];
  int          cur_row;
  int          cur_col;
  logic [7:0]  text_color;

  // console results predicted for accepted requests, oldest first
  res_t        predicted_results [$];
  res_t        want;
  res_t        got;

  // move the cursor to the next line, scroll when it falls off the bottom
  function automatic bit start_new_line();
    cur_col = 0;
    cur_row++;
    if (cur_row < ROWS) begin
      return 1'b0;
    end
    for (int k = 0; k < (ROWS - 1) * COLS; k++) begin
      screen_img[k] = screen_img[k + COLS];
    end
    for (int k = (ROWS - 1) * COLS; k < CELLS; k++) begin
      screen_img[k] = '0;
    end
    cur_row = ROWS - 1;
    return 1'b1;
  endfunction

  // apply one request to the shadow and return the result it must produce
  function automatic res_t advance_console(cmd_t req);
    res_t r;
    bit   on_screen;
    int   idx;
    r = '0;
    on_screen = (int'(req.cell_col) < COLS) && (int'(req.cell_row) < ROWS);
    idx = int'(req.cell_row) * COLS + int'(req.cell_col);
    case (req.cmd)
      CMD_PUT_CHAR: begin
        if (req.char_code == NEWLINE_CODE) begin
          r.scrolled = start_new_line();
        end else begin
          screen_img[cur_row * COLS + cur_col] = {text_color, req.char_code};
          cur_col++;
          if (cur_col >= COLS) begin
            r.scrolled = start_new_line();
          end
        end
      end
      CMD_PUT_AT: begin
        if (on_screen) begin
          screen_img[idx] = {text_color, req.char_code};
        end else begin
          r.bad_position = 1'b1;
        end
      end
      CMD_CLEAR: begin
        for (int k = 0; k < CELLS; k++) begin
          screen_img[k] = {text_color, SPACE_CODE};
        end
      end
      CMD_READ_CELL: begin
        if (on_screen) begin
          r.cell_word = screen_img[idx];
        end else begin
          r.bad_position = 1'b1;
        end
      end
    endcase
    r.cursor_row_out = 5'(cur_row);
    r.cursor_col_out = 7'(cur_col);
    return r;
  endfunction

  // one field of a result against its prediction
  function automatic void check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (got_v !== want_v) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want_v, got_v);
      mismatch_count++;
    end
  endfunction

  // watch both channels at every rising edge
  always @(posedge clk) begin
    if (rst) begin
      predicted_results.delete();
      for (int k = 0; k < CELLS; k++) begin
        screen_img[k] = '0;
      end
      cur_row = 0;
      cur_col = 0;
      text_color = TEXT_COLOR_RESET;
      mismatch_count = 0;
    end else begin
      if (color_we) begin
        text_color = color_wdata;
      end
      if (cmd_mon.valid && cmd_mon.ready) begin
        predicted_results.push_back(advance_console(cmd_mon.payload));
      end
      if (res_mon.valid && res_mon.ready) begin
        got = res_mon.payload;
        if (predicted_results.size() == 0) begin
          $display("%0t: result with no request outstanding, expected none, got %h",
                   $time, got);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("cell_word", want.cell_word, got.cell_word);
          check_field("cursor_row_out", 16'(want.cursor_row_out), 16'(got.cursor_row_out));
          check_field("cursor_col_out", 16'(want.cursor_col_out), 16'(got.cursor_col_out));
          check_field("scrolled", 16'(want.scrolled), 16'(got.scrolled));
          check_field("bad_position", 16'(want.bad_position), 16'(got.bad_position));
        end
      end
    end
    results_owed = predicted_results.size();
  end

endmodule

/* tb/text_console_writer_core_test.sv */
`timescale 1ns / 1ps

module text_console_writer_core_test;
  import tcw_pkg::*;

  localparam int COLS         = SCREEN_COLS_DEF;
  localparam int ROWS         = SCREEN_ROWS_DEF;
  localparam int RESET_CYCLES = 6;
  localparam int CYCLE_LIMIT  = 20_000_000;
  localparam int PHASE_COUNT  = 10;
  localparam int PHASE_ITEMS  = 148;
  localparam int BURST_ITEMS  = 40;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 2100;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        color_we = 1'b0;
  logic [7:0]  color_wdata = '0;

  int unsigned mismatch_count;
  int unsigned results_owed;
  int unsigned cycle_count = 0;
  int          hold_requests = 0;
  bit          steady_tail = 1'b0;
  bit          burst_mode = 1'b0;

  tcw_stream_if #(.payload_t(cmd_t)) cmd_if ();
  tcw_stream_if #(.payload_t(res_t)) res_if ();

  text_console_writer_core DUT (
    .clk         (clk),
    .rst         (rst),
    .color_we    (color_we),
    .color_wdata (color_wdata),
    .cmd_stream  (cmd_if),
    .res_stream  (res_if)
  );

  console_result_check result_check (
    .clk            (clk),
    .rst            (rst),
    .color_we       (color_we),
    .color_wdata    (color_wdata),
    .cmd_mon        (cmd_if),
    .res_mon        (res_if),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always #1 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: short random stalls, one long hold-off on demand
  initial begin : result_drain
    int hold;
    int holds_served;
    holds_served = 0;
    res_if.ready <= 1'b0;
    @(negedge clk);
    forever begin
      hold = 0;
      if (hold_requests != holds_served) begin
        holds_served++;
        hold = LONG_HOLD;
      end else if (!steady_tail && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 13);
      end
      if (hold > 0) begin
        res_if.ready <= 1'b0;
        repeat (hold) @(negedge clk);
      end
      res_if.ready <= 1'b1;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // occasional gap before a request
  task automatic maybe_pause();
    if (!steady_tail && !burst_mode && $urandom_range(0, 9) == 0) begin
      cmd_if.valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(negedge clk);
    end
  endtask

  // offer one request and hold it until taken; called and returns at a falling edge
  task automatic send_request(cmd_code_t op, logic [7:0] ch, logic [6:0] col,
                              logic [4:0] row);
    cmd_t req;
    req.cmd = op;
    req.char_code = ch;
    req.cell_col = col;
    req.cell_row = row;
    maybe_pause();
    cmd_if.valid <= 1'b1;
    cmd_if.payload <= req;
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // no request outstanding and the block taking requests again
  task automatic wait_until_idle();
    cmd_if.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    @(posedge clk);
    while (!cmd_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic set_text_color(logic [7:0] value);
    wait_until_idle();
    color_we <= 1'b1;
    color_wdata <= value;
    @(negedge clk);
    color_we <= 1'b0;
  endtask

  // coordinates: mostly on screen, some anywhere, some forced off screen
  task automatic pick_position(bit near_bottom, output logic [6:0] col,
                               output logic [4:0] row);
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 70) begin
      col = 7'($urandom_range(0, COLS - 1));
      row = near_bottom ? 5'($urandom_range(ROWS - 5, ROWS - 1))
                        : 5'($urandom_range(0, ROWS - 1));
    end else if (sel < 85) begin
      col = 7'($urandom_range(0, 127));
      row = 5'($urandom_range(0, 31));
    end else if (sel < 93) begin
      col = 7'($urandom_range(COLS, 127));
      row = 5'($urandom_range(0, 31));
    end else begin
      col = 7'($urandom_range(0, 127));
      row = 5'($urandom_range(ROWS, 31));
    end
  endtask

  // random mix: text runs, positioned writes, reads, rare clears
  task automatic run_phase(int item_goal);
    int         sent;
    int         sel;
    int         run_len;
    bit         with_newlines;
    logic [7:0] ch;
    logic [6:0] col;
    logic [4:0] row;
    sent = 0;
    while (sent < item_goal) begin
      sel = $urandom_range(0, 99);
      if (sel < 50) begin
        // text run, half of them without newlines so lines wrap
        run_len = $urandom_range(1, 90);
        if (run_len > item_goal - sent) begin
          run_len = item_goal - sent;
        end
        with_newlines = 1'($urandom_range(0, 1));
        repeat (run_len) begin
          ch = (with_newlines && $urandom_range(0, 11) == 0) ? NEWLINE_CODE
                                                             : 8'($urandom_range(0, 255));
          send_request(CMD_PUT_CHAR, ch, 7'($urandom), 5'($urandom));
          sent++;
        end
      end else if (sel < 72) begin
        pick_position(1'b0, col, row);
        send_request(CMD_PUT_AT, 8'($urandom), col, row);
        sent++;
      end else if (sel < 96) begin
        pick_position(1'($urandom_range(0, 1)), col, row);
        send_request(CMD_READ_CELL, 8'($urandom), col, row);
        sent++;
      end else begin
        send_request(CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [7:0] color;
    logic [6:0] col;
    logic [4:0] row;
    cmd_if.valid <= 1'b0;
    cmd_if.payload <= '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // directed: reset contents, field extremes, off-screen coordinates
    send_request(CMD_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ_CELL, 8'hFF, 7'(COLS - 1), 5'(ROWS - 1));
    send_request(CMD_PUT_CHAR, 8'h41, 7'd0, 5'd0);
    send_request(CMD_PUT_CHAR, 8'h00, 7'd127, 5'd31);
    send_request(CMD_PUT_CHAR, 8'hFF, 7'd0, 5'd0);
    send_request(CMD_PUT_CHAR, NEWLINE_CODE, 7'd0, 5'd0);
    send_request(CMD_PUT_AT, 8'hFF, 7'(COLS - 1), 5'(ROWS - 1));
    send_request(CMD_PUT_AT, 8'h00, 7'd0, 5'd0);
    send_request(CMD_PUT_AT, 8'h55, 7'(COLS), 5'd0);
    send_request(CMD_PUT_AT, 8'hAA, 7'd127, 5'd31);
    send_request(CMD_PUT_AT, 8'h33, 7'd0, 5'(ROWS));
    send_request(CMD_READ_CELL, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
    send_request(CMD_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ_CELL, 8'h00, 7'(COLS), 5'd0);
    send_request(CMD_READ_CELL, 8'h00, 7'd127, 5'd31);
    send_request(CMD_READ_CELL, 8'h00, 7'd0, 5'(ROWS));
    send_request(CMD_READ_CELL, 8'h00, 7'd2, 5'd0);
    set_text_color(8'hFF);
    send_request(CMD_PUT_AT, 8'h7F, 7'd40, 5'd12);
    send_request(CMD_READ_CELL, 8'h00, 7'd40, 5'd12);
    send_request(CMD_CLEAR, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ_CELL, 8'h00, 7'd0, 5'd0);
    send_request(CMD_READ_CELL, 8'h00, 7'(COLS - 1), 5'(ROWS - 1));
    send_request(CMD_PUT_CHAR, SPACE_CODE, 7'd0, 5'd0);

    // random phases, each under its own attribute byte
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        0: color = 8'h00;
        1: color = 8'hFF;
        2: color = 8'h5A;
        3: color = 8'hA5;
        default: color = 8'($urandom);
      endcase
      steady_tail = (phase == PHASE_COUNT - 1);
      set_text_color(color);
      if ($urandom_range(0, 1) == 1) begin
        send_request(CMD_CLEAR, 8'($urandom), 7'($urandom), 5'($urandom));
      end
      if (phase == 2) begin
        // keep requests coming while the result side holds off
        burst_mode = 1'b1;
        wait_until_idle();
        hold_requests++;
        repeat (BURST_ITEMS) begin
          pick_position(1'b0, col, row);
          send_request(CMD_PUT_AT, 8'($urandom), col, row);
        end
        burst_mode = 1'b0;
      end
      run_phase(PHASE_ITEMS);
    end

    // drain and settle
    cmd_if.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_stream_if.sv
hw/rtl/tcw_ram.sv
hw/rtl/text_console_writer_core.sv
tb/console_result_check.sv
tb/text_console_writer_core_test.sv
